// File: hdl/pag_pkg.sv
`default_nettype none

package pag_pkg;

  // Fixed field widths of the register map and the result word
  localparam int RANK_W       = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 6;
  localparam int PERM_W       = 24;
  localparam int PERM_FIELD_W = 3;
  localparam int SIZE_FIELD_W = 16;
  localparam int OUT_IDX_W    = 32;
  localparam int OUT_LEN_W    = 16;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_RANK       = 3'd0;
  localparam logic [2:0] REG_SIZES_LOW  = 3'd1;
  localparam logic [2:0] REG_SIZES_HIGH = 3'd2;
  localparam logic [2:0] REG_PERM_ORDER = 3'd3;
  localparam logic [2:0] REG_ROW_MODE   = 3'd4;

  // Reset values of the register map
  localparam logic [RANK_W-1:0]     RANK_RST  = 4'd1;
  localparam logic [CFG_DATA_W-1:0] SIZES_RST = 64'h0001_0001_0001_0001;
  localparam logic [PERM_W-1:0]     PERM_RST  = 24'hFAC688;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_MUL,
    ST_PASS_ACC,
    ST_EMIT,
    ST_ADV,
    ST_ADV_SUB,
    ST_FINISH
  } pag_state_t;

endpackage

`default_nettype wire

// File: hdl/pag_mul.sv
`default_nettype none

// Shared multiplier with registered product
module pag_mul #(
  parameter int A_W = 33,
  parameter int B_W = 16
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic      [A_W+B_W-1:0] p
);

  logic [A_W+B_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// File: hdl/permute_address_generator.sv
`default_nettype none

// Permute address generator: walks a row-major tensor of up to MAX_DIMS dims
// in permuted output order and hands out source/destination index words.
// Input channel: in_valid/in_ready carry one word, in_restart. A restart
//   recomputes the strides and clears the coordinate and both indices.
// Result channel: out_valid/out_ready carry src/dst index, row stride,
//   row length, last (walk wraps after this word) and too_large.
// APB-style register port (64-bit data, register i at byte 8*i, pready tied
//   high); the user must write it only while the block is idle (not enforced).
// Steps per word:
//   accept, a stride/size pass over all MAX_DIMS dims with an added
//   accumulate step per dim in use, emit, advance (a step per position
//   skipped or stepped, an added subtract step per position that
//   carries, a step on full wrap) and hand-over.
//   One shared multiplier serves the size product and the carry
//   correction, so words go one at a time.
// A word with a zero size in use produces nothing (after any restart).
// Reset loads the default register map, a zero coordinate and strides
//   for rank 1. When the receiver stalls, the finished word sits in the
//   output register; the next word is still accepted and worked on, and
//   waits at hand-over until the output register frees.
module permute_address_generator #(
  parameter int MAX_DIMS   = 8,
  parameter int INDEX_BITS = 32,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_restart,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [pag_pkg::OUT_IDX_W-1:0]         out_src_index,
  output logic [pag_pkg::OUT_IDX_W-1:0]         out_dst_index,
  output logic [pag_pkg::OUT_IDX_W-1:0]         out_row_stride,
  output logic [pag_pkg::OUT_LEN_W-1:0]         out_row_length,
  output logic                                  out_last,
  output logic                                  out_too_large,
  // register port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pag_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [pag_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [pag_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready
);

  localparam int R_W    = $clog2(MAX_DIMS + 1);
  localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int ACC_W  = INDEX_BITS + 1;
  localparam int PROD_W = ACC_W + SIZE_BITS;
  localparam int RW     = pag_pkg::RANK_W;
  localparam logic [PROD_W-1:0] LIMIT = PROD_W'(1) << INDEX_BITS;

  // ---------------------------------------------------------------------
  // Register map
  // ---------------------------------------------------------------------
  logic [RW-1:0]                  rank_r;
  logic [pag_pkg::CFG_DATA_W-1:0] sizes_low_r;
  logic [pag_pkg::CFG_DATA_W-1:0] sizes_high_r;
  logic [pag_pkg::PERM_W-1:0]     perm_r;
  logic                           row_mode_r;
  logic                           cfg_wr;
  logic [2:0]                     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_comb begin
    case (cfg_idx)
      pag_pkg::REG_RANK:       prdata = pag_pkg::CFG_DATA_W'(rank_r);
      pag_pkg::REG_SIZES_LOW:  prdata = sizes_low_r;
      pag_pkg::REG_SIZES_HIGH: prdata = sizes_high_r;
      pag_pkg::REG_PERM_ORDER: prdata = pag_pkg::CFG_DATA_W'(perm_r);
      pag_pkg::REG_ROW_MODE:   prdata = pag_pkg::CFG_DATA_W'(row_mode_r);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Walk state
  // ---------------------------------------------------------------------
  pag_pkg::pag_state_t state_r, state_nxt;

  logic [SIZE_BITS-1:0]  coord_r  [MAX_DIMS];
  logic [INDEX_BITS-1:0] stride_r [MAX_DIMS];
  logic [INDEX_BITS-1:0] src_r;
  logic [INDEX_BITS-1:0] dst_r;

  // per-word working registers
  logic [DIM_W-1:0]      dcnt_r;
  logic [R_W-1:0]        n_r;
  logic [ACC_W-1:0]      acc_r;
  logic                  ovf_r;
  logic                  zero_r;
  logic                  restart_r;
  logic                  wrapped_r;
  logic [INDEX_BITS-1:0] pend_src_r;
  logic [INDEX_BITS-1:0] pend_dst_r;
  logic [INDEX_BITS-1:0] pend_stride_r;
  logic [SIZE_BITS-1:0]  pend_len_r;
  logic [SIZE_BITS-1:0]  inc_r;

  // output stage
  logic                            out_valid_r;
  logic [pag_pkg::OUT_IDX_W-1:0]   out_src_r;
  logic [pag_pkg::OUT_IDX_W-1:0]   out_dst_r;
  logic [pag_pkg::OUT_IDX_W-1:0]   out_stride_r;
  logic [pag_pkg::OUT_LEN_W-1:0]   out_len_r;
  logic                            out_last_r;
  logic                            out_big_r;

  // ---------------------------------------------------------------------
  // Shared dim select: one dim looked up per cycle
  // ---------------------------------------------------------------------
  logic [R_W-1:0]        eff_rank;
  logic [2:0]            sel_pos;
  logic [2:0]            sel_d;
  logic                  sel_in_range;
  logic [SIZE_BITS-1:0]  sel_size;
  logic [INDEX_BITS-1:0] sel_stride;
  logic [SIZE_BITS-1:0]  sel_coord;
  logic [SIZE_BITS:0]    sel_nc;
  logic [2*pag_pkg::CFG_DATA_W-1:0] sizes_all;

  assign eff_rank  = (rank_r > RW'(MAX_DIMS)) ? R_W'(MAX_DIMS) : R_W'(rank_r);
  assign sizes_all = {sizes_high_r, sizes_low_r};

  always_comb begin
    case (state_r)
      pag_pkg::ST_EMIT: sel_pos = 3'(eff_rank - 1'b1);
      default:          sel_pos = 3'(n_r - 1'b1);
    endcase
  end

  always_comb begin
    case (state_r)
      pag_pkg::ST_PASS_MUL: sel_d = 3'(dcnt_r);
      default: sel_d = perm_r[pag_pkg::PERM_FIELD_W*sel_pos +: pag_pkg::PERM_FIELD_W];
    endcase
  end

  assign sel_in_range = (RW'(sel_d) < RW'(eff_rank));
  assign sel_size     = sizes_all[pag_pkg::SIZE_FIELD_W*sel_d +: SIZE_BITS];
  assign sel_stride   = stride_r[sel_d[DIM_W-1:0]];
  assign sel_coord    = coord_r[sel_d[DIM_W-1:0]];
  assign sel_nc       = {1'b0, sel_coord} + 1'b1;

  // ---------------------------------------------------------------------
  // Shared multiplier: size product in the pass, carry correction later
  // ---------------------------------------------------------------------
  logic                  mul_en;
  logic [ACC_W-1:0]      mul_a;
  logic [SIZE_BITS-1:0]  mul_b;
  logic [PROD_W-1:0]     prod;

  pag_mul #(
    .A_W (ACC_W),
    .B_W (SIZE_BITS)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic in_fire;
  logic out_free;
  logic adv_live;
  logic adv_carry;
  logic finish_load;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pag_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pag_pkg::ST_PASS_MUL;
      end
      pag_pkg::ST_PASS_MUL: begin
        if (sel_in_range) state_nxt = pag_pkg::ST_PASS_ACC;
        else if (dcnt_r == '0) state_nxt = pag_pkg::ST_EMIT;
      end
      pag_pkg::ST_PASS_ACC: begin
        if (dcnt_r == '0) state_nxt = pag_pkg::ST_EMIT;
        else state_nxt = pag_pkg::ST_PASS_MUL;
      end
      pag_pkg::ST_EMIT: begin
        state_nxt = zero_r ? pag_pkg::ST_IDLE : pag_pkg::ST_ADV;
      end
      pag_pkg::ST_ADV: begin
        if (n_r == '0) state_nxt = pag_pkg::ST_FINISH;
        else if (sel_in_range) begin
          state_nxt = adv_carry ? pag_pkg::ST_ADV_SUB : pag_pkg::ST_FINISH;
        end
      end
      pag_pkg::ST_ADV_SUB: state_nxt = pag_pkg::ST_ADV;
      pag_pkg::ST_FINISH: begin
        if (out_free) state_nxt = pag_pkg::ST_IDLE;
      end
      default: state_nxt = pag_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    mul_en      = 1'b0;
    mul_a       = acc_r;
    mul_b       = sel_size;
    adv_live    = 1'b0;
    adv_carry   = 1'b0;
    finish_load = 1'b0;
    case (state_r)
      pag_pkg::ST_IDLE: in_ready = 1'b1;
      pag_pkg::ST_PASS_MUL: mul_en = sel_in_range;
      pag_pkg::ST_ADV: begin
        adv_live  = (n_r != '0) && sel_in_range;
        adv_carry = adv_live && (sel_nc >= {1'b0, sel_size});
        mul_en    = adv_carry;
        mul_a     = {1'b0, sel_stride};
        mul_b     = sel_coord;
      end
      pag_pkg::ST_FINISH: finish_load = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pag_pkg::ST_IDLE;
      rank_r       <= pag_pkg::RANK_RST;
      sizes_low_r  <= pag_pkg::SIZES_RST;
      sizes_high_r <= pag_pkg::SIZES_RST;
      perm_r       <= pag_pkg::PERM_RST;
      row_mode_r   <= 1'b0;
      src_r        <= '0;
      dst_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        coord_r[i]  <= '0;
        // strides of the reset map: rank 1, all sizes 1
        stride_r[i] <= (i == 0) ? INDEX_BITS'(1) : '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        case (cfg_idx)
          pag_pkg::REG_RANK:       rank_r       <= pwdata[RW-1:0];
          pag_pkg::REG_SIZES_LOW:  sizes_low_r  <= pwdata;
          pag_pkg::REG_SIZES_HIGH: sizes_high_r <= pwdata;
          pag_pkg::REG_PERM_ORDER: perm_r       <= pwdata[pag_pkg::PERM_W-1:0];
          pag_pkg::REG_ROW_MODE:   row_mode_r   <= pwdata[0];
          default: ;
        endcase
      end

      if (in_fire) begin
        dcnt_r    <= DIM_W'(MAX_DIMS - 1);
        acc_r     <= ACC_W'(1);
        ovf_r     <= 1'b0;
        zero_r    <= 1'b0;
        restart_r <= in_restart;
        if (in_restart) begin
          src_r <= '0;
          dst_r <= '0;
          for (int i = 0; i < MAX_DIMS; i++) coord_r[i] <= '0;
        end
      end

      // stride pass, last dim first; also size product and zero check
      if (state_r == pag_pkg::ST_PASS_MUL) begin
        if (sel_in_range) begin
          if (restart_r) stride_r[dcnt_r] <= acc_r[INDEX_BITS-1:0];
          if (sel_size == '0) zero_r <= 1'b1;
        end else begin
          if (restart_r) stride_r[dcnt_r] <= '0;
          if (dcnt_r != '0) dcnt_r <= dcnt_r - 1'b1;
        end
      end

      if (state_r == pag_pkg::ST_PASS_ACC) begin
        // low bits stay exact modulo the index range; top bit only
        // holds a product equal to the limit itself
        if (prod > LIMIT) begin
          ovf_r <= 1'b1;
          acc_r <= {1'b0, prod[INDEX_BITS-1:0]};
        end else begin
          acc_r <= prod[ACC_W-1:0];
        end
        if (dcnt_r != '0) dcnt_r <= dcnt_r - 1'b1;
      end

      if (state_r == pag_pkg::ST_EMIT) begin
        pend_src_r <= src_r;
        pend_dst_r <= dst_r;
        if (eff_rank == '0) begin
          pend_stride_r <= row_mode_r ? INDEX_BITS'(1) : '0;
          pend_len_r    <= row_mode_r ? SIZE_BITS'(1) : '0;
          inc_r         <= SIZE_BITS'(1);
        end else begin
          pend_stride_r <= (row_mode_r && sel_in_range) ? sel_stride : '0;
          pend_len_r    <= !row_mode_r ? '0 :
                           (sel_in_range ? sel_size : SIZE_BITS'(1));
          inc_r         <= !row_mode_r ? SIZE_BITS'(1) :
                           (sel_in_range ? sel_size : SIZE_BITS'(1));
        end
        // row mode leaves the last output position to the descriptor
        if (row_mode_r) n_r <= (eff_rank > R_W'(1)) ? eff_rank - 1'b1 : '0;
        else n_r <= eff_rank;
      end

      if (state_r == pag_pkg::ST_ADV) begin
        if (n_r == '0) begin
          wrapped_r <= 1'b1;
        end else if (!sel_in_range) begin
          n_r <= n_r - 1'b1;
        end else if (!adv_carry) begin
          src_r <= src_r + sel_stride;
          coord_r[sel_d[DIM_W-1:0]] <= sel_nc[SIZE_BITS-1:0];
          wrapped_r <= 1'b0;
        end
      end

      // carry: net change is minus coordinate times stride
      if (state_r == pag_pkg::ST_ADV_SUB) begin
        src_r <= src_r - prod[INDEX_BITS-1:0];
        coord_r[sel_d[DIM_W-1:0]] <= '0;
        n_r <= n_r - 1'b1;
      end

      if (finish_load) begin
        out_valid_r  <= 1'b1;
        out_src_r    <= pag_pkg::OUT_IDX_W'(pend_src_r);
        out_dst_r    <= pag_pkg::OUT_IDX_W'(pend_dst_r);
        out_stride_r <= pag_pkg::OUT_IDX_W'(pend_stride_r);
        out_len_r    <= pag_pkg::OUT_LEN_W'(pend_len_r);
        out_last_r   <= wrapped_r;
        out_big_r    <= ovf_r;
        dst_r        <= wrapped_r ? '0 : dst_r + INDEX_BITS'(inc_r);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_src_index  = out_src_r;
  assign out_dst_index  = out_dst_r;
  assign out_row_stride = out_stride_r;
  assign out_row_length = out_len_r;
  assign out_last       = out_last_r;
  assign out_too_large  = out_big_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_restart) |=> (src_r == '0 && dst_r == '0))
    else $error("restart did not clear the indices");

  a_wrap_resets_dst: assert property (@(posedge clk) disable iff (!rst_n)
    (finish_load && wrapped_r) |=> (dst_r == '0 && out_last))
    else $error("wrapped walk did not reset the destination offset");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pag_pkg::ST_ADV) |-> (n_r <= R_W'(MAX_DIMS)))
    else $error("advance position beyond rank");

  a_no_emit_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pag_pkg::ST_EMIT && zero_r) |=> !finish_load)
    else $error("word emitted with a zero-size dimension");

endmodule

`default_nettype wire

// File: verif/permute_address_generator_tb.sv
`default_nettype none

module permute_address_generator_tb;

  // One result word as the block hands it out
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] stride;
    logic [15:0] len;
    logic        last;
    logic        big;
  } addr_word_t;

  // Tracks the walk alongside the block: a copy of the register map and the
  // walk state, and the words still owed by the block, oldest first.
  class addr_walk_checker;
    logic [3:0]  rank;
    logic [63:0] sizes_lo;
    logic [63:0] sizes_hi;
    logic [23:0] perm;
    logic        row_mode;
    logic [15:0] coord[8];
    logic [31:0] strides[8];
    logic [31:0] src_idx;
    logic [31:0] dst_off;
    addr_word_t  due_words[$];
    int          bad_words;

    function new();
      rank     = pag_pkg::RANK_RST;
      sizes_lo = pag_pkg::SIZES_RST;
      sizes_hi = pag_pkg::SIZES_RST;
      perm     = pag_pkg::PERM_RST;
      row_mode = 1'b0;
      foreach (coord[i]) coord[i] = '0;
      src_idx   = '0;
      dst_off   = '0;
      bad_words = 0;
      refresh_strides();
    endfunction

    function int unsigned eff_rank();
      return (rank > 8) ? 8 : rank;
    endfunction

    function logic [15:0] dim_size(int d);
      return (d < 4) ? sizes_lo[16*(d%4) +: 16] : sizes_hi[16*(d%4) +: 16];
    endfunction

    function int unsigned perm_at(int p);
      return perm[3*p +: 3];
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        pag_pkg::REG_RANK:       rank     = v[3:0];
        pag_pkg::REG_SIZES_LOW:  sizes_lo = v;
        pag_pkg::REG_SIZES_HIGH: sizes_hi = v;
        pag_pkg::REG_PERM_ORDER: perm     = v[23:0];
        pag_pkg::REG_ROW_MODE:   row_mode = v[0];
        default: ;
      endcase
    endfunction

    // Row-major strides, innermost dim last; dims beyond the rank get 0
    function void refresh_strides();
      logic [63:0] acc;
      int unsigned r;
      r   = eff_rank();
      acc = 64'd1;
      for (int d = 7; d >= 0; d--) begin
        if (d >= r) begin
          strides[d] = '0;
        end else begin
          strides[d] = acc[31:0];
          acc = {32'd0, acc[31:0] * 32'(dim_size(d))};
          acc = {32'd0, acc[31:0]};
        end
      end
    endfunction

    function bit oversize();
      logic [63:0] limit, p, s;
      bit over;
      int unsigned r;
      r     = eff_rank();
      limit = 64'h1_0000_0000;
      p     = 64'd1;
      over  = 1'b0;
      for (int d = 0; d < r; d++) begin
        s = 64'(dim_size(d));
        if (s == 0) return 1'b0;
        if (!over) begin
          if (p > limit / s) over = 1'b1;
          else p = p * s;
        end
      end
      return over || (p > limit);
    endfunction

    // Carry through positions top..0; 1 when the whole walk wraps
    function bit step_walk(int top);
      int unsigned r, d;
      logic [16:0] nc;
      logic [63:0] prod;
      r = eff_rank();
      for (int p = top; p >= 0; p--) begin
        d = perm_at(p);
        if (d >= r) continue;
        nc      = 17'(coord[d]) + 17'd1;
        src_idx = src_idx + strides[d];
        if (nc >= 17'(dim_size(d))) begin
          prod     = 64'(nc) * 64'(strides[d]);
          src_idx  = src_idx - prod[31:0];
          coord[d] = '0;
        end else begin
          coord[d] = nc[15:0];
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_word(bit restart);
      int unsigned r, ld;
      logic [31:0] rlen, rstride;
      addr_word_t  w;
      if (restart) begin
        refresh_strides();
        foreach (coord[i]) coord[i] = '0;
        src_idx = '0;
        dst_off = '0;
      end
      r = eff_rank();
      for (int d = 0; d < r; d++)
        if (dim_size(d) == 0) return;
      if (r == 0) begin
        rlen    = 32'd1;
        rstride = 32'd1;
      end else begin
        ld      = perm_at(r - 1);
        rlen    = (ld >= r) ? 32'd1 : 32'(dim_size(ld));
        rstride = (ld >= r) ? 32'd0 : strides[ld];
      end
      w.src    = src_idx;
      w.dst    = dst_off;
      w.stride = row_mode ? rstride : 32'd0;
      w.len    = row_mode ? rlen[15:0] : 16'd0;
      w.big    = oversize();
      if (row_mode) begin
        w.last  = step_walk(int'(r) - 2);
        dst_off = dst_off + rlen;
      end else begin
        w.last  = step_walk(int'(r) - 1);
        dst_off = dst_off + 32'd1;
      end
      if (w.last) dst_off = '0;
      due_words.push_back(w);
    endfunction

    function void check_word(addr_word_t got);
      addr_word_t w;
      if (due_words.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word: src %h dst %h", got.src, got.dst);
        return;
      end
      w = due_words.pop_front();
      if (got != w) begin
        bad_words++;
        if (bad_words <= 10)
          $display({"mismatch: exp src %h dst %h stride %h len %h last %b big %b,",
                    " got src %h dst %h stride %h len %h last %b big %b"},
                   w.src, w.dst, w.stride, w.len, w.last, w.big,
                   got.src, got.dst, got.stride, got.len, got.last, got.big);
      end
    endfunction

    function int pending();
      return due_words.size();
    endfunction
  endclass

  // Block hand-over is fully serial.
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_valid   = 1'b0;
  logic                           in_ready;
  logic                           in_restart = 1'b0;
  logic                           out_valid;
  logic                           out_ready  = 1'b0;
  logic [pag_pkg::OUT_IDX_W-1:0]  out_src_index;
  logic [pag_pkg::OUT_IDX_W-1:0]  out_dst_index;
  logic [pag_pkg::OUT_IDX_W-1:0]  out_row_stride;
  logic [pag_pkg::OUT_LEN_W-1:0]  out_row_length;
  logic                           out_last;
  logic                           out_too_large;
  logic                           psel       = 1'b0;
  logic                           penable    = 1'b0;
  logic                           pwrite     = 1'b0;
  logic [pag_pkg::CFG_ADDR_W-1:0] paddr      = '0;
  logic [pag_pkg::CFG_DATA_W-1:0] pwdata     = '0;
  logic [pag_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  addr_walk_checker sb;

  int tx_idle_pct = 0;   // chance per cycle that the sender holds back
  int rx_idle_pct = 0;   // chance per cycle that the receiver holds back
  int words_sent  = 0;
  int hold_asks   = 0;   // bumped by the stimulus to ask for a long stall
  int hold_done   = 0;
  int hold_left   = 0;

  permute_address_generator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_src_index (out_src_index),
    .out_dst_index (out_dst_index),
    .out_row_stride(out_row_stride),
    .out_row_length(out_row_length),
    .out_last      (out_last),
    .out_too_large (out_too_large),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop, several times the slowest legal run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: checks each word taken, then picks next cycle's ready.
  // All reads here see the values from just before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word({out_src_index, out_dst_index, out_row_stride,
                     out_row_length, out_last, out_too_large});
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Register write: setup cycle, then access; pready is tied high but
  // honoured anyway.
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  // Wait for every owed word, then give a word with a zero size in use
  // time to die out inside the block.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One input word. Idle mix follows the run's progress: sender slow and
  // receiver very slow first, then the reverse, then both flat out.
  task automatic send_word(input bit rs);
    int gap;
    if (words_sent < 650) begin
      tx_idle_pct = 29;
      rx_idle_pct = 84;
    end else if (words_sent < 1300) begin
      tx_idle_pct = 84;
      rx_idle_pct = 29;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= rs;
    do @(posedge clk); while (!in_ready);
    sb.note_word(rs);
    words_sent++;
  endtask

  // A run of words; the first carries the given restart, later ones
  // restart now and then.
  task automatic send_words(input int n, input bit first_rs);
    for (int w = 0; w < n; w++)
      send_word((w == 0) ? first_rs : ($urandom_range(99) < 4));
    in_valid <= 1'b0;
  endtask

  task automatic setup_all(input logic [3:0] rk, input logic [63:0] lo,
                           input logic [63:0] hi, input logic [23:0] pm,
                           input bit md);
    drain();
    cfg_write(pag_pkg::REG_RANK, 64'(rk));
    cfg_write(pag_pkg::REG_SIZES_LOW, lo);
    cfg_write(pag_pkg::REG_SIZES_HIGH, hi);
    cfg_write(pag_pkg::REG_PERM_ORDER, 64'(pm));
    cfg_write(pag_pkg::REG_ROW_MODE, 64'(md));
  endtask

  // Random setting: mostly small sizes so walks wrap often, a proper
  // permutation most of the time, now and then a partial rewrite, and
  // now and then no restart so the walk carries on over a changed map.
  task automatic random_phase();
    logic [3:0]  rk;
    logic [15:0] sz[8];
    logic [23:0] pm;
    int          ord[8];
    int          n, j, t, k;
    bit          all_regs;
    k = $urandom_range(99);
    if (k < 5) rk = 4'd0;
    else if (k < 75) rk = 4'($urandom_range(4, 1));
    else if (k < 90) rk = 4'($urandom_range(8, 5));
    else rk = 4'($urandom_range(15, 9));
    for (int i = 0; i < 8; i++) begin
      k = $urandom_range(99);
      if (k < 2) sz[i] = 16'd0;
      else if (k < 80) sz[i] = 16'($urandom_range(4, 1));
      else if (k < 90) sz[i] = 16'($urandom_range(65535, 1));
      else if (k < 95) sz[i] = 16'hFFFF;
      else sz[i] = 16'($urandom_range(16, 5));
    end
    n  = (rk > 8) ? 8 : rk;
    pm = 24'($urandom);
    if ($urandom_range(99) < 70) begin
      for (int i = 0; i < 8; i++) ord[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j      = $urandom_range(i);
        t      = ord[i];
        ord[i] = ord[j];
        ord[j] = t;
      end
      for (int i = 0; i < n; i++) pm[3*i +: 3] = 3'(ord[i]);
    end
    drain();
    all_regs = ($urandom_range(99) < 80);
    if (all_regs || $urandom_range(1)) cfg_write(pag_pkg::REG_RANK, 64'(rk));
    if (all_regs || $urandom_range(1))
      cfg_write(pag_pkg::REG_SIZES_LOW, {sz[3], sz[2], sz[1], sz[0]});
    if (all_regs || $urandom_range(1))
      cfg_write(pag_pkg::REG_SIZES_HIGH, {sz[7], sz[6], sz[5], sz[4]});
    if (all_regs || $urandom_range(1))
      cfg_write(pag_pkg::REG_PERM_ORDER, 64'(pm));
    if (all_regs || $urandom_range(1))
      cfg_write(pag_pkg::REG_ROW_MODE, 64'($urandom_range(1)));
    send_words($urandom_range(60, 10), ($urandom_range(99) < 80));
  endtask

  initial begin
    bit held;
    held = 1'b0;
    sb   = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset map: rank 1, unit sizes; first word uses the reset strides
    send_words(1, 1'b0);
    send_words(1, 1'b1);

    // rank zero, element then row mode
    setup_all(4'd0, pag_pkg::SIZES_RST, pag_pkg::SIZES_RST, pag_pkg::PERM_RST,
              1'b0);
    send_words(1, 1'b1);
    drain();
    cfg_write(pag_pkg::REG_ROW_MODE, 64'd1);
    send_words(1, 1'b0);

    // 2x3x2 walked in order (2,0,1), then row mode mid-walk
    setup_all(4'd3, 64'h0001_0002_0003_0002, pag_pkg::SIZES_RST, 24'o102, 1'b0);
    send_words(5, 1'b1);
    drain();
    cfg_write(pag_pkg::REG_ROW_MODE, 64'd1);
    send_words(3, 1'b0);

    // zero size in use: nothing comes back; zero size beyond the rank is fine
    setup_all(4'd3, 64'h0001_0001_0000_0002, pag_pkg::SIZES_RST, 24'o102, 1'b0);
    send_words(2, 1'b1);
    setup_all(4'd2, 64'h0001_0001_0002_0003, 64'h0000_0001_0001_0001, 24'o01, 1'b0);
    send_words(1, 1'b1);

    // largest tensor, reversed order: flagged as too large
    setup_all(4'd8, '1, '1, 24'o01234567, 1'b1);
    send_words(2, 1'b1);
    // two full dims still fit the index range
    drain();
    cfg_write(pag_pkg::REG_RANK, 64'd2);
    send_words(1, 1'b1);
    // exactly 2^32 elements is not flagged
    setup_all(4'd3, 64'h0001_0004_8000_8000, pag_pkg::SIZES_RST, 24'o210, 1'b0);
    send_words(1, 1'b1);

    // repeated entry and an entry beyond the rank
    setup_all(4'd3, 64'h0001_0002_0002_0003, pag_pkg::SIZES_RST, 24'o511, 1'b0);
    send_words(4, 1'b1);

    // rank above the maximum acts as eight
    setup_all(4'd12, 64'h0002_0002_0002_0002, 64'h0002_0002_0002_0002,
              24'o76543210, 1'b0);
    send_words(2, 1'b1);

    while (words_sent < 1950) begin
      if (!held && words_sent >= 1300) begin
        // long receiver stall while words keep coming: block backs up
        held = 1'b1;
        setup_all(4'd3, 64'h0001_0004_0003_0002, pag_pkg::SIZES_RST, 24'o021,
                  1'b0);
        hold_asks++;
        send_words(25, 1'b1);
      end else begin
        random_phase();
      end
    end

    drain();
    if (sb.bad_words == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hdl/pag_pkg.sv
hdl/pag_mul.sv
hdl/permute_address_generator.sv
verif/permute_address_generator_tb.sv
